### sv/hrdc_pkg.sv
`timescale 1ns / 1ps
// hrdc_pkg: shared types and constants for the hid report descriptor classifier
// no dependencies; imported by the parser and the top level
package hrdc_pkg;

    // descriptor length limit and byte counter width
    localparam int MAX_DESC_BYTES = 256;
    localparam int BYTE_CNT_W     = $clog2(MAX_DESC_BYTES + 1);

    // item header fields
    localparam logic [7:0]  LONG_ITEM_HDR    = 8'hFE;
    localparam logic [1:0]  SIZE_CODE_FOUR   = 2'h3;
    localparam logic [1:0]  TYPE_MAIN        = 2'h0;
    localparam logic [1:0]  TYPE_GLOBAL      = 2'h1;
    localparam logic [1:0]  TYPE_LOCAL       = 2'h2;
    localparam logic [3:0]  TAG_USAGE_PAGE   = 4'h0;
    localparam logic [3:0]  TAG_USAGE        = 4'h0;
    localparam logic [3:0]  TAG_COLLECTION   = 4'hA;
    localparam logic [31:0] COLL_APPLICATION = 32'h0000_0001;

    // usage codes on the generic desktop page
    localparam logic [15:0] PAGE_GEN_DESKTOP = 16'h0001;
    localparam logic [15:0] USAGE_MOUSE      = 16'h0002;
    localparam logic [15:0] USAGE_JOYSTICK   = 16'h0004;
    localparam logic [15:0] USAGE_GAMEPAD    = 16'h0005;
    localparam logic [15:0] USAGE_KEYBOARD   = 16'h0006;

    // interface class codes for the boot path
    localparam logic [7:0]  SUBCLASS_BOOT    = 8'h01;
    localparam logic [7:0]  PROTO_KEYBOARD   = 8'h01;
    localparam logic [7:0]  PROTO_MOUSE      = 8'h02;

    typedef enum logic [1:0] {
        KIND_UNKNOWN    = 2'd0,
        KIND_KEYBOARD   = 2'd1,
        KIND_MOUSE      = 2'd2,
        KIND_CONTROLLER = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] desc_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] iface_subclass;
        logic [7:0] iface_protocol;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  from_boot;
    } t_result;

endpackage

### sv/hrdc_in_if.sv
`timescale 1ns / 1ps
// hrdc_in_if: descriptor byte channel, valid/ready with payload
// no dependencies
interface hrdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] desc_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] iface_subclass;
    logic [7:0] iface_protocol;

    modport source (
        output valid, desc_byte, first_byte, last_byte, iface_subclass, iface_protocol,
        input  ready
    );
    modport sink (
        input  valid, desc_byte, first_byte, last_byte, iface_subclass, iface_protocol,
        output ready
    );
endinterface

### sv/hrdc_out_if.sv
`timescale 1ns / 1ps
// hrdc_out_if: classification result channel, valid/ready with payload
// no dependencies
interface hrdc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] device_kind;
    logic       from_boot_path;

    modport source (
        output valid, device_kind, from_boot_path,
        input  ready
    );
    modport sink (
        input  valid, device_kind, from_boot_path,
        output ready
    );
endinterface

### sv/hrdc_parser.sv
`timescale 1ns / 1ps
// hrdc_parser: parse state and per-byte item decode of the report descriptor
// depends on hrdc_pkg
module hrdc_parser
    import hrdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  t_item   i_item,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HEADER    = 3'd1,
        PH_DATA      = 3'd2,
        PH_LONG_SIZE = 3'd3,
        PH_LONG_SKIP = 3'd4,
        PH_DONE      = 3'd5
    } t_phase;

    t_phase                r_phase,      n_phase;
    logic [8:0]            r_skip,       n_skip;
    logic [2:0]            r_idx,        n_idx;
    logic [2:0]            r_size,       n_size;
    logic [31:0]           r_accum,      n_accum;
    logic [1:0]            r_type,       n_type;
    logic [3:0]            r_tag,        n_tag;
    logic [15:0]           r_page,       n_page;
    logic [15:0]           r_usage,      n_usage;
    logic                  r_have_page,  n_have_page;
    logic                  r_have_usage, n_have_usage;
    logic [BYTE_CNT_W-1:0] r_count,      n_count;

    logic       w_boot;
    logic       w_finish;
    logic       w_got;
    t_kind      w_kind;
    logic [1:0] w_code;

    always_comb begin
        n_phase      = r_phase;
        n_skip       = r_skip;
        n_idx        = r_idx;
        n_size       = r_size;
        n_accum      = r_accum;
        n_type       = r_type;
        n_tag        = r_tag;
        n_page       = r_page;
        n_usage      = r_usage;
        n_have_page  = r_have_page;
        n_have_usage = r_have_usage;
        n_count      = r_count;
        o_result     = '0;
        w_boot       = 1'b0;
        w_finish     = 1'b0;
        w_got        = 1'b0;
        w_kind       = KIND_UNKNOWN;
        w_code       = i_item.desc_byte[1:0];

        if (i_take) begin
            // first byte drops any parse in flight
            if (i_item.first_byte) begin
                n_phase      = PH_HEADER;
                n_skip       = '0;
                n_idx        = '0;
                n_size       = '0;
                n_accum      = '0;
                n_type       = '0;
                n_tag        = '0;
                n_page       = '0;
                n_usage      = '0;
                n_have_page  = 1'b0;
                n_have_usage = 1'b0;
                n_count      = '0;
                if (i_item.iface_subclass == SUBCLASS_BOOT &&
                    (i_item.iface_protocol == PROTO_KEYBOARD ||
                     i_item.iface_protocol == PROTO_MOUSE)) begin
                    w_boot             = 1'b1;
                    n_phase            = PH_DONE;
                    o_result.valid     = 1'b1;
                    o_result.from_boot = 1'b1;
                    o_result.kind      = (i_item.iface_protocol == PROTO_KEYBOARD) ?
                                         KIND_KEYBOARD : KIND_MOUSE;
                end
            end

            if (!w_boot && n_phase != PH_IDLE && n_phase != PH_DONE) begin
                case (n_phase)
                    PH_HEADER: begin
                        if (i_item.desc_byte == LONG_ITEM_HDR) begin
                            n_phase = PH_LONG_SIZE;
                        end else begin
                            n_type  = i_item.desc_byte[3:2];
                            n_tag   = i_item.desc_byte[7:4];
                            n_size  = (w_code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, w_code};
                            n_idx   = '0;
                            n_accum = '0;
                            if (n_size == 3'd0) begin
                                w_finish = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        // little-endian gather
                        n_accum = n_accum |
                                  (32'(i_item.desc_byte) << {n_idx[1:0], 3'b000});
                        n_idx   = n_idx + 3'd1;
                        if (n_idx >= n_size) begin
                            n_phase  = PH_HEADER;
                            w_finish = 1'b1;
                        end
                    end
                    PH_LONG_SIZE: begin
                        n_skip  = {1'b0, i_item.desc_byte} + 9'd1;
                        n_phase = PH_LONG_SKIP;
                    end
                    PH_LONG_SKIP: begin
                        if (n_skip != 9'd0) begin
                            n_skip = n_skip - 9'd1;
                        end
                        if (n_skip == 9'd0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase

                // act on a complete short item
                if (w_finish) begin
                    if (n_type == TYPE_GLOBAL && n_tag == TAG_USAGE_PAGE) begin
                        n_page      = n_accum[15:0];
                        n_have_page = 1'b1;
                    end else if (n_type == TYPE_LOCAL && n_tag == TAG_USAGE) begin
                        n_usage      = n_accum[15:0];
                        n_have_usage = 1'b1;
                    end else if (n_type == TYPE_MAIN && n_tag == TAG_COLLECTION &&
                                 n_accum == COLL_APPLICATION &&
                                 n_have_page && n_have_usage) begin
                        w_got = 1'b1;
                        if (n_page == PAGE_GEN_DESKTOP) begin
                            if (n_usage == USAGE_KEYBOARD) begin
                                w_kind = KIND_KEYBOARD;
                            end else if (n_usage == USAGE_MOUSE) begin
                                w_kind = KIND_MOUSE;
                            end else if (n_usage == USAGE_JOYSTICK ||
                                         n_usage == USAGE_GAMEPAD) begin
                                w_kind = KIND_CONTROLLER;
                            end
                        end
                    end
                end

                if (n_count < BYTE_CNT_W'(MAX_DESC_BYTES)) begin
                    n_count = n_count + BYTE_CNT_W'(1);
                end

                if (w_got) begin
                    n_phase        = PH_DONE;
                    o_result.valid = 1'b1;
                    o_result.kind  = w_kind;
                end else if (i_item.last_byte || n_count >= BYTE_CNT_W'(MAX_DESC_BYTES)) begin
                    n_phase        = PH_DONE;
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_UNKNOWN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_skip       <= '0;
            r_idx        <= '0;
            r_size       <= '0;
            r_accum      <= '0;
            r_type       <= '0;
            r_tag        <= '0;
            r_page       <= '0;
            r_usage      <= '0;
            r_have_page  <= 1'b0;
            r_have_usage <= 1'b0;
            r_count      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_skip       <= n_skip;
            r_idx        <= n_idx;
            r_size       <= n_size;
            r_accum      <= n_accum;
            r_type       <= n_type;
            r_tag        <= n_tag;
            r_page       <= n_page;
            r_usage      <= n_usage;
            r_have_page  <= n_have_page;
            r_have_usage <= n_have_usage;
            r_count      <= n_count;
        end
    end

    // a result always closes the parse
    a_result_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |=> r_phase == PH_DONE)
        else $error("parse not closed after result");

    // nothing is reported from a closed or idle parse without a first byte
    a_quiet_when_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE || r_phase == PH_IDLE) && !i_item.first_byte |-> !o_result.valid)
        else $error("result from a closed parse");

    // the byte counter never passes the descriptor limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= BYTE_CNT_W'(MAX_DESC_BYTES))
        else $error("byte counter past limit");

endmodule

### sv/hid_report_descriptor_classifier.sv
`timescale 1ns / 1ps
// hid_report_descriptor_classifier: top level, input register, parser and result register
// depends on hrdc_pkg, hrdc_in_if, hrdc_out_if and hrdc_parser
//
//  channel  | dir | transaction carries
//  ---------+-----+-----------------------------------------------------------------
//  i_in     | in  | desc_byte, first_byte, last_byte, iface_subclass, iface_protocol
//  o_out    | out | device_kind, from_boot_path (at most one per descriptor)
//
// one byte per cycle sustained while o_out does not stall; a byte taken into the input register
// is parsed from there, and its result, if any, is loaded into the result register and
// offered on o_out from then on
// reset is synchronous and active low; it clears the parse to idle and empties both
// registers, so bytes before the first descriptor start are ignored
// a waiting result that is not taken stalls the parse stage; the input register still
// takes a byte if it is empty, then i_in.ready stays low until the result is taken
module hid_report_descriptor_classifier
    import hrdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrdc_in_if.sink     i_in,
    hrdc_out_if.source  o_out
);

    // input register
    logic    r_in_vld;
    t_item   r_in_item;

    // result register
    logic    r_out_vld;
    t_kind   r_out_kind;
    logic    r_out_boot;

    logic    w_advance;
    t_result w_result;

    // the parse stage moves when the result register is free or being drained
    assign w_advance  = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.desc_byte      <= i_in.desc_byte;
            r_in_item.first_byte     <= i_in.first_byte;
            r_in_item.last_byte      <= i_in.last_byte;
            r_in_item.iface_subclass <= i_in.iface_subclass;
            r_in_item.iface_protocol <= i_in.iface_protocol;
        end
    end

    hrdc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_advance),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // load a fresh result, or drop the old one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance && w_result.valid) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result.valid) begin
            r_out_kind <= w_result.kind;
            r_out_boot <= w_result.from_boot;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.device_kind    = r_out_kind;
    assign o_out.from_boot_path = r_out_boot;

    // a waiting result is never overwritten by the parse stage
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |-> !w_advance)
        else $error("result register overwritten");

    // a held byte is not replaced while the parse stage is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_advance |-> !i_in.ready)
        else $error("input register overwritten");

    // boot path answers only keyboard or mouse
    a_boot_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_boot |-> r_out_kind == KIND_KEYBOARD || r_out_kind == KIND_MOUSE)
        else $error("boot path gave another kind");

endmodule

### sim/hrdc_kind_check_pkg.sv
`timescale 1ns / 1ps
// hrdc_kind_check_pkg: device kind predictor and result scoreboard for the classifier bench
// depends on hrdc_pkg for item fields, header codes and the kind enum
package hrdc_kind_check_pkg;
    import hrdc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DATA,
        PH_LONG_SIZE,
        PH_LONG_SKIP,
        PH_DONE
    } t_phase;

    typedef struct {
        t_kind kind;
        logic  boot;
    } t_kind_due;

    class kind_scoreboard;
        t_phase      phase;
        logic [8:0]  skip_left;
        int unsigned data_idx;
        int unsigned data_len;
        logic [31:0] accum;
        logic [1:0]  cur_type;
        logic [3:0]  cur_tag;
        logic [15:0] last_page;
        logic [15:0] last_usage;
        bit          page_valid;
        bit          usage_valid;
        int unsigned taken;

        t_kind_due   kinds_due[$];
        int          mismatch_count;
        int          results_seen;

        function new();
            clear_parse();
            mismatch_count = 0;
            results_seen   = 0;
        endfunction

        function void clear_parse();
            phase       = PH_IDLE;
            skip_left   = '0;
            data_idx    = 0;
            data_len    = 0;
            accum       = '0;
            cur_type    = '0;
            cur_tag     = '0;
            last_page   = '0;
            last_usage  = '0;
            page_valid  = 0;
            usage_valid = 0;
            taken       = 0;
        endfunction

        function void expect_kind(t_kind kind, logic boot);
            t_kind_due d;
            d.kind = kind;
            d.boot = boot;
            kinds_due.push_back(d);
        endfunction

        function int pending();
            return kinds_due.size();
        endfunction

        // acts on a complete short item; 1 when an application collection decides
        function bit item_decides(output t_kind kind);
            kind = KIND_UNKNOWN;
            if (cur_type == TYPE_GLOBAL && cur_tag == TAG_USAGE_PAGE) begin
                last_page  = accum[15:0];
                page_valid = 1;
            end else if (cur_type == TYPE_LOCAL && cur_tag == TAG_USAGE) begin
                last_usage  = accum[15:0];
                usage_valid = 1;
            end else if (cur_type == TYPE_MAIN && cur_tag == TAG_COLLECTION &&
                         accum == COLL_APPLICATION && page_valid && usage_valid) begin
                if (last_page == PAGE_GEN_DESKTOP) begin
                    if (last_usage == USAGE_KEYBOARD)
                        kind = KIND_KEYBOARD;
                    else if (last_usage == USAGE_MOUSE)
                        kind = KIND_MOUSE;
                    else if (last_usage == USAGE_JOYSTICK || last_usage == USAGE_GAMEPAD)
                        kind = KIND_CONTROLLER;
                end
                return 1;
            end
            return 0;
        endfunction

        function bit parse_byte(logic [7:0] b, output t_kind kind);
            kind = KIND_UNKNOWN;
            case (phase)
                PH_HEADER: begin
                    if (b == LONG_ITEM_HDR) begin
                        phase = PH_LONG_SIZE;
                        return 0;
                    end
                    cur_type = b[3:2];
                    cur_tag  = b[7:4];
                    data_len = (b[1:0] == SIZE_CODE_FOUR) ? 4 : int'(b[1:0]);
                    data_idx = 0;
                    accum    = '0;
                    if (data_len == 0)
                        return item_decides(kind);
                    phase = PH_DATA;
                    return 0;
                end
                PH_DATA: begin
                    accum = accum | (32'(b) << (8 * (data_idx % 4)));
                    data_idx++;
                    if (data_idx >= data_len) begin
                        phase = PH_HEADER;
                        return item_decides(kind);
                    end
                    return 0;
                end
                PH_LONG_SIZE: begin
                    skip_left = {1'b0, b} + 9'd1;
                    phase     = PH_LONG_SKIP;
                    return 0;
                end
                PH_LONG_SKIP: begin
                    if (skip_left != 0)
                        skip_left--;
                    if (skip_left == 0)
                        phase = PH_HEADER;
                    return 0;
                end
                default: return 0;
            endcase
        endfunction

        // notes one accepted byte transaction and queues the answer it causes
        function void note_byte(t_item it);
            t_kind kind;
            bit    decided;
            if (it.first_byte) begin
                clear_parse();
                if (it.iface_subclass == SUBCLASS_BOOT &&
                    (it.iface_protocol == PROTO_KEYBOARD || it.iface_protocol == PROTO_MOUSE)) begin
                    phase = PH_DONE;
                    expect_kind((it.iface_protocol == PROTO_KEYBOARD) ? KIND_KEYBOARD : KIND_MOUSE,
                                1'b1);
                    return;
                end
                phase = PH_HEADER;
            end
            if (phase == PH_IDLE || phase == PH_DONE)
                return;
            decided = parse_byte(it.desc_byte, kind);
            if (taken < MAX_DESC_BYTES)
                taken++;
            if (decided) begin
                phase = PH_DONE;
                expect_kind(kind, 1'b0);
            end else if (it.last_byte || taken >= MAX_DESC_BYTES) begin
                phase = PH_DONE;
                expect_kind(KIND_UNKNOWN, 1'b0);
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        task check_result(logic [1:0] kind, logic boot);
            t_kind_due d;
            results_seen++;
            if (kinds_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d boot %0b", kind, boot));
                return;
            end
            d = kinds_due.pop_front();
            if (kind !== d.kind)
                report_mismatch($sformatf("device_kind %0d, expected %0d", kind, d.kind));
            if (boot !== d.boot)
                report_mismatch($sformatf("from_boot_path %0b, expected %0b", boot, d.boot));
        endtask
    endclass

endpackage

### sim/hid_report_descriptor_classifier_tb.sv
`timescale 1ns / 1ps
// hid_report_descriptor_classifier_tb: drives descriptor bytes into the classifier and checks
// every device kind answer; depends on hrdc_pkg, the two channel interfaces and hrdc_kind_check_pkg
module hid_report_descriptor_classifier_tb;
    import hrdc_pkg::*;
    import hrdc_kind_check_pkg::*;

    // drain pad covers input register, parse stage and result register with margin
    localparam int DRAIN_PAD    = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 75;
    localparam int HOLD_CYCLES  = 200;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hrdc_in_if  in_ch ();
    hrdc_out_if out_ch ();

    hid_report_descriptor_classifier uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    kind_scoreboard sb;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   scatter_last  = 0;
    bit   hold_start    = 0;
    int   hold_left     = 0;
    int   cycle_count   = 0;
    int   bytes_sent    = 0;
    logic [7:0] desc_q[$];

    // free-running clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result sink: a long hold-off is counted here once requested, else random stalls
    always @(negedge i_clk) begin
        if (hold_start) begin
            hold_start = 0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: sample both channels on the rising edge; check the answer before noting the
    // new byte so the expectation order follows the transaction order
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.device_kind, out_ch.from_boot_path);
            if (in_ch.valid && in_ch.ready) begin
                it.desc_byte      = in_ch.desc_byte;
                it.first_byte     = in_ch.first_byte;
                it.last_byte      = in_ch.last_byte;
                it.iface_subclass = in_ch.iface_subclass;
                it.iface_protocol = in_ch.iface_protocol;
                sb.note_byte(it);
            end
        end
    end

    // one byte transaction; payload changes on the falling edge, held until accepted
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [7:0] sub, input logic [7:0] proto);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.desc_byte      <= b;
        in_ch.first_byte     <= first;
        in_ch.last_byte      <= last;
        in_ch.iface_subclass <= sub;
        in_ch.iface_protocol <= proto;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // sends desc_q as one descriptor; subclass and protocol only matter on the first byte
    task automatic send_descriptor(input logic [7:0] sub, input logic [7:0] proto,
                                   input bit end_flag);
        logic last;
        for (int i = 0; i < desc_q.size(); i++) begin
            last = (i == desc_q.size() - 1 && end_flag) ||
                   (scatter_last && $urandom_range(99) == 0);
            if (i == 0)
                send_byte(desc_q[i], 1'b1, last, sub, proto);
            else
                send_byte(desc_q[i], 1'b0, last, 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        end
    endtask

    // sender pauses until every answer is back, then lets the pipeline settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    // short item: header then 0, 1, 2 or 4 little-endian data bytes
    function automatic void push_short(logic [7:0] hdr, logic [31:0] data);
        int n;
        n = (hdr[1:0] == SIZE_CODE_FOUR) ? 4 : int'(hdr[1:0]);
        desc_q.push_back(hdr);
        for (int i = 0; i < n; i++)
            desc_q.push_back(data[8*i +: 8]);
    endfunction

    // mostly generic desktop, sometimes consumer, sometimes anything at all
    function automatic logic [31:0] pick_page();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return 32'(PAGE_GEN_DESKTOP);
        else if (r == 7)
            return 32'h0000_000C;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_usage();
        case ($urandom_range(5))
            0: return 32'(USAGE_KEYBOARD);
            1: return 32'(USAGE_MOUSE);
            2: return 32'(USAGE_JOYSTICK);
            3: return 32'(USAGE_GAMEPAD);
            4: return {16'($urandom_range(65535)), USAGE_KEYBOARD};
            default: return $urandom;
        endcase
    endfunction

    // well-formed item soup with random content, often closed by an application collection;
    // some descriptors are cut short and a few are plain noise
    function automatic void build_random_descriptor();
        int         n_items;
        int         keep;
        int         skip;
        logic [1:0] code;
        logic [7:0] hdr;
        desc_q.delete();
        if ($urandom_range(9) == 0) begin
            n_items = $urandom_range(1, 12);
            for (int i = 0; i < n_items; i++)
                desc_q.push_back(8'($urandom_range(255)));
            return;
        end
        n_items = $urandom_range(1, 7);
        for (int i = 0; i < n_items; i++) begin
            code = 2'($urandom_range(3));
            case ($urandom_range(9))
                0, 1: push_short({TAG_USAGE_PAGE, TYPE_GLOBAL, code}, pick_page());
                2, 3: push_short({TAG_USAGE, TYPE_LOCAL, code}, pick_usage());
                4: push_short({TAG_COLLECTION, TYPE_MAIN, code},
                              ($urandom_range(9) < 7) ? COLL_APPLICATION : 32'($urandom));
                5: begin
                    // long item: size byte then size + 1 bytes skipped
                    skip = ($urandom_range(29) == 0) ? $urandom_range(255) : $urandom_range(6);
                    desc_q.push_back(LONG_ITEM_HDR);
                    desc_q.push_back(8'(skip));
                    for (int j = 0; j <= skip; j++)
                        desc_q.push_back(8'($urandom_range(255)));
                end
                6: begin
                    // reserved item type, avoiding the long item header
                    hdr = {4'($urandom_range(15)), 2'b11, code};
                    if (hdr == LONG_ITEM_HDR)
                        hdr[1:0] = 2'b01;
                    push_short(hdr, $urandom);
                end
                default: begin
                    hdr = 8'($urandom_range(255));
                    if (hdr == LONG_ITEM_HDR)
                        hdr = 8'h81;
                    push_short(hdr, $urandom);
                end
            endcase
        end
        if ($urandom_range(1) == 0) begin
            push_short({TAG_USAGE_PAGE, TYPE_GLOBAL, 2'($urandom_range(1, 3))}, pick_page());
            push_short({TAG_USAGE, TYPE_LOCAL, 2'($urandom_range(1, 3))}, pick_usage());
            push_short({TAG_COLLECTION, TYPE_MAIN, 2'b01}, COLL_APPLICATION);
        end
        if ($urandom_range(4) == 0) begin
            keep = $urandom_range(1, desc_q.size());
            while (desc_q.size() > keep)
                void'(desc_q.pop_back());
        end
    endfunction

    task automatic random_descriptor();
        logic [7:0] sub;
        logic [7:0] proto;
        int         noise;
        build_random_descriptor();
        if ($urandom_range(9) < 3) begin
            sub   = SUBCLASS_BOOT;
            proto = 8'($urandom_range(3));
        end else begin
            sub   = 8'($urandom_range(255));
            proto = 8'($urandom_range(255));
        end
        send_descriptor(sub, proto, $urandom_range(9) < 6);
        // stray bytes with no descriptor start
        if ($urandom_range(4) == 0) begin
            noise = $urandom_range(1, 4);
            repeat (noise)
                send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct);
        int start_bytes;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        start_bytes   = bytes_sent;
        while (bytes_sent - start_bytes < PHASE_BYTES)
            random_descriptor();
        drain();
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.desc_byte      = '0;
        in_ch.first_byte     = 1'b0;
        in_ch.last_byte      = 1'b0;
        in_ch.iface_subclass = '0;
        in_ch.iface_protocol = '0;
        out_ch.ready         = 1'b0;
        sb = new();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 64;

        // bytes before any descriptor start are dropped
        send_byte(8'h05, 1'b0, 1'b0, SUBCLASS_BOOT, PROTO_KEYBOARD);
        send_byte(8'hA1, 1'b0, 1'b1, 8'h00, 8'h00);

        // boot keyboard and boot mouse answer on the first byte, the rest is ignored
        desc_q = '{8'h05, 8'h01};
        send_descriptor(SUBCLASS_BOOT, PROTO_KEYBOARD, 1'b1);
        desc_q = '{8'h00};
        send_descriptor(SUBCLASS_BOOT, PROTO_MOUSE, 1'b0);

        // plain keyboard, mouse and joystick application collections
        desc_q = '{8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01};
        send_descriptor(8'h00, 8'h00, 1'b0);
        desc_q = '{8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01};
        send_descriptor(8'hFF, 8'hFF, 1'b0);
        desc_q = '{8'h05, 8'h01, 8'h09, 8'h04, 8'hA1, 8'h01, 8'h33};
        send_descriptor(SUBCLASS_BOOT, 8'h00, 1'b1);

        // gamepad through two-byte items
        desc_q = '{8'h06, 8'h01, 8'h00, 8'h0A, 8'h05, 8'h00, 8'hA2, 8'h01, 8'h00};
        send_descriptor(8'h00, PROTO_KEYBOARD, 1'b0);

        // consumer page gives unknown; four-byte usage keeps only its low half
        desc_q = '{8'h07, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h09, 8'h01, 8'hA1, 8'h01};
        send_descriptor(8'h00, 8'h00, 1'b0);
        desc_q = '{8'h05, 8'h01, 8'h0B, 8'h06, 8'h00, 8'h01, 8'h00, 8'hA1, 8'h01};
        send_descriptor(8'h00, 8'h00, 1'b0);

        // early application collection, physical collection, long item, reserved items
        desc_q = '{8'hA1, 8'h01, 8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h00,
                   8'hFE, 8'h02, 8'hAA, 8'hBB, 8'hCC, 8'h0D, 8'h5A,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hA1, 8'h01};
        send_descriptor(8'h00, 8'h00, 1'b0);

        // item cut short by the end flag
        desc_q = '{8'h05, 8'h01, 8'h09};
        send_descriptor(8'h00, 8'h00, 1'b1);

        // new descriptor start in the middle of a parse drops the old one
        desc_q = '{8'h05, 8'h01, 8'h09};
        send_descriptor(8'h00, 8'h00, 1'b0);
        desc_q = '{8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01};
        send_descriptor(8'h00, 8'h00, 1'b0);

        // long item running past the end; end flag on a lone first byte
        desc_q = '{8'h05, 8'h01, 8'hFE, 8'h10, 8'hAA, 8'hBB};
        send_descriptor(8'h00, 8'h00, 1'b1);
        desc_q = '{8'h00};
        send_descriptor(8'h00, 8'h00, 1'b1);

        // zero-size long item skips one byte, then a keyboard
        desc_q = '{8'hFE, 8'h00, 8'h11, 8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01};
        send_descriptor(8'h00, 8'h00, 1'b0);
        drain();

        scatter_last = 1;

        // sender light, receiver heavy
        random_phase(9, 64);

        // long receiver hold-off while boot answers pile up and back-pressure the input
        hold_start    = 1;
        send_idle_pct = 0;
        for (int i = 0; i < 12; i++) begin
            desc_q = '{8'($urandom_range(255))};
            send_descriptor(SUBCLASS_BOOT, (i % 2 == 0) ? PROTO_KEYBOARD : PROTO_MOUSE, 1'b0);
        end
        drain();

        // sender heavy, receiver light; one descriptor hits the length limit and is answered unknown
        send_idle_pct = 64;
        recv_idle_pct = 9;
        desc_q.delete();
        for (int i = 0; i < MAX_DESC_BYTES + 20; i++)
            desc_q.push_back({4'($urandom_range(15)), 2'b11, 2'b00});
        send_descriptor(8'h00, 8'h00, 1'b0);
        random_phase(64, 9);

        // back to back on both sides
        random_phase(0, 0);

        if (sb.mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
